>>> src/ssne_pkg.sv
//------------------------------------------------------------------------------
// ssne_pkg
// Shared types, constants and status codes for the sorted set extract unit.
//------------------------------------------------------------------------------
package ssne_pkg;

	localparam int unsigned ValW        = 31;
	localparam int unsigned DefCapacity = 256;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [2:0] ST_INSERTED    = 3'd0;
	localparam logic [2:0] ST_PRESENT     = 3'd1;
	localparam logic [2:0] ST_EMPTY       = 3'd2;
	localparam logic [2:0] ST_REMOVED     = 3'd3;
	localparam logic [2:0] ST_NEAREST     = 3'd4;
	localparam logic [2:0] ST_FULL        = 3'd5;

	typedef struct packed {
		logic            opcode;
		logic [ValW-1:0] key_value;
	} ssne_in_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ValW-1:0] removed_value;
	} ssne_out_t;

endpackage

>>> src/ssne_mem.sv
//------------------------------------------------------------------------------
// ssne_mem
// Two-port value store, one read and one write per cycle, registered read.
//------------------------------------------------------------------------------
module ssne_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [ssne_pkg::ValW-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic [ssne_pkg::ValW-1:0] rdata
);
	import ssne_pkg::*;

	logic [ValW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/sorted_set_nearest_extract_unit.sv
//------------------------------------------------------------------------------
// sorted_set_nearest_extract_unit
// Sorted set of distinct values with insert and nearest-value removal.
//------------------------------------------------------------------------------
// channel | signals                   | transfer
// --------+---------------------------+------------------------------------
// command | start, busy, cmd          | start high while busy low
// result  | done, result              | done high, one cycle, no stall
//
// Unless the set is empty, an item scans the store from entry 0 until it finds
// the first value >= key or reaches the last entry. Each scanned entry passes
// through S_SCAN (read issue) and S_CHECK (compare on the registered data).
// Where a gap must be opened or closed, the tail then shifts one entry per cycle.
// Reset clears the entry count and the FSM state; stored values need no clearing.
// The result cannot be stalled; busy stays high until done has been shown.
//------------------------------------------------------------------------------
module sorted_set_nearest_extract_unit #(
	parameter int unsigned CAPACITY = ssne_pkg::DefCapacity
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ssne_pkg::ssne_in_t cmd,
	output logic               done,
	output ssne_pkg::ssne_out_t result
);
	import ssne_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1; // read issued for idx_q
	localparam logic [2:0] S_CHECK = 3'd2; // read data valid for idx_q
	localparam logic [2:0] S_NEAR  = 3'd3; // not used; no transition enters it
	localparam logic [2:0] S_SHIFT = 3'd4; // move loop
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;     // scan index / shift pointer
	logic            op_q;
	logic [ValW-1:0] key_q;
	logic [ValW-1:0] lo_val_q;  // value at idx-1 (previous scanned)
	logic            ins_q;     // shift direction: 1 = insert (up)
	logic            rd_pend_q; // shift: read issued last cycle
	logic [CW-1:0]   end_q;
	logic            done_q;
	ssne_out_t       res_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [ValW-1:0] wdata, rdata;

	ssne_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// distances for nearest pick
	logic [ValW-1:0] d_lo, d_hi;
	assign d_lo = key_q - lo_val_q;
	assign d_hi = rdata - key_q;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		if (state_q == S_SHIFT) begin
			if (ins_q) begin
				// insert: read idx-1, rdata holds entry idx, lands at idx+1
				raddr = AW'(idx_q - CW'(1));
				we    = rd_pend_q;
				waddr = AW'(idx_q + CW'(1));
			end else begin
				// remove: read idx+1, rdata holds entry idx, lands at idx-1
				raddr = AW'(idx_q + CW'(1));
				we    = rd_pend_q;
				waddr = AW'(idx_q - CW'(1));
			end
		end else if (state_q == S_DONE && ins_q && op_q == OP_INSERT) begin
			we    = res_q.status == ST_INSERTED;
			waddr = idx_q[AW-1:0];
			wdata = key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			done_q    <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			done_q <= state_q == S_DONE;
			case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						op_q                <= cmd.opcode;
						key_q               <= cmd.key_value;
						idx_q               <= '0;
						res_q.removed_value <= '0;
						if (count_q == '0) begin
							res_q.status <= (cmd.opcode == OP_REMOVE) ? ST_EMPTY : ST_INSERTED;
							ins_q        <= cmd.opcode == OP_INSERT;
							state_q      <= S_DONE;
						end else begin
							ins_q   <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: state_q <= S_CHECK;
				S_CHECK: begin
					if (rdata >= key_q) begin
						if (rdata == key_q) begin
							if (op_q == OP_INSERT) begin
								res_q.status <= ST_PRESENT;
								state_q      <= S_DONE;
							end else begin
								res_q.status        <= ST_REMOVED;
								res_q.removed_value <= key_q;
								end_q               <= idx_q;
								state_q             <= S_SHIFT;
								rd_pend_q           <= 1'b0;
							end
						end else if (op_q == OP_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								res_q.status <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								res_q.status <= ST_INSERTED;
								ins_q        <= 1'b1;
								end_q        <= idx_q;
								idx_q        <= count_q;
								rd_pend_q    <= 1'b0;
								state_q      <= S_SHIFT;
							end
						end else begin
							res_q.status <= ST_NEAREST;
							rd_pend_q    <= 1'b0;
							state_q      <= S_SHIFT;
							if (idx_q != '0 && d_lo <= d_hi) begin
								res_q.removed_value <= lo_val_q;
								idx_q               <= idx_q - CW'(1);
							end else begin
								res_q.removed_value <= rdata;
							end
						end
					end else if (idx_q + CW'(1) == count_q) begin
						// all stored values below key
						if (op_q == OP_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								res_q.status <= ST_FULL;
							end else begin
								res_q.status <= ST_INSERTED;
								ins_q        <= 1'b1;
								idx_q        <= count_q;
							end
							state_q <= S_DONE;
						end else begin
							res_q.status        <= ST_NEAREST;
							res_q.removed_value <= rdata;
							count_q             <= count_q - CW'(1);
							state_q             <= S_DONE;
						end
					end else begin
						lo_val_q <= rdata;
						idx_q    <= idx_q + CW'(1);
						state_q  <= S_SCAN;
					end
				end
				S_SHIFT: begin
					// insert: idx walks down from count to the gap, gap kept in idx
					// remove: idx walks up from the hole to count-1
					if (ins_q) begin
						if (idx_q == end_q) begin
							rd_pend_q <= 1'b0;
							state_q   <= S_DONE;
						end else begin
							rd_pend_q <= 1'b1;
							idx_q     <= idx_q - CW'(1);
						end
					end else begin
						if (idx_q + CW'(1) >= count_q) begin
							rd_pend_q <= 1'b0;
							count_q   <= count_q - CW'(1);
							state_q   <= S_DONE;
						end else begin
							rd_pend_q <= 1'b1;
							idx_q     <= idx_q + CW'(1);
						end
					end
				end
				S_DONE: begin
					if (ins_q && res_q.status == ST_INSERTED) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Shift is pipelined: the read issued last cycle arrives as rdata and is
	// written one entry over while the next read goes out, one entry per cycle.

	assign busy   = state_q != S_IDLE || done_q;
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("count exceeds capacity");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("busy low during result");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_set_nearest_extract_unit. A behavioral copy
// of the sorted set predicts every result. Directed tests cover the empty,
// exact, nearest, tie, out-of-range and full cases. Random traffic with
// random gaps between transfers follows.
//------------------------------------------------------------------------------
module testbench;
	import ssne_pkg::*;

	localparam int unsigned CAP       = DefCapacity;
	localparam int unsigned RAND_ITEMS = 80;
	localparam int unsigned MAX_CYCLES = 4000000;
	localparam logic [ValW-1:0] KEY_MAX = {ValW{1'b1}};

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	ssne_in_t  cmd;
	logic      done;
	ssne_out_t result;

	sorted_set_nearest_extract_unit #(.CAPACITY(CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// Predictor state: ascending copy of the stored values.
	logic [ValW-1:0] set_shadow[$];
	// Results still owed by the block, oldest first.
	ssne_out_t       pending_results[$];

	int unsigned err_count = 0;
	int unsigned sent_count;
	int unsigned checked_count = 0;
	int unsigned cycle_count = 0;
	bit          burst_mode;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_results.size());
			$display("** sorted_set_nearest_extract_unit: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned key_distance(logic [ValW-1:0] a, logic [ValW-1:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	// Apply one command to the shadow set and return what the block must report.
	function automatic ssne_out_t apply_to_shadow(ssne_in_t c);
		ssne_out_t       r;
		int              pos;
		int              hi;
		int              lo;
		int              pick;
		int              n;
		r   = '0;
		n   = set_shadow.size();
		pos = 0;
		while (pos < n && set_shadow[pos] < c.key_value) pos++;
		if (c.opcode == OP_INSERT) begin
			if (pos < n && set_shadow[pos] == c.key_value) begin
				r.status = ST_PRESENT;
			end else if (n >= CAP) begin
				r.status = ST_FULL;
			end else begin
				set_shadow.insert(pos, c.key_value);
				r.status = ST_INSERTED;
			end
		end else begin
			if (n == 0) begin
				r.status = ST_EMPTY;
			end else if (pos < n && set_shadow[pos] == c.key_value) begin
				r.status        = ST_REMOVED;
				r.removed_value = c.key_value;
				set_shadow.delete(pos);
			end else begin
				// Neighbors around the target; ties go to the lower one.
				hi   = (pos < n) ? pos : n - 1;
				lo   = (hi > 0) ? hi - 1 : hi;
				pick = hi;
				if (key_distance(c.key_value, set_shadow[lo]) <=
				    key_distance(c.key_value, set_shadow[hi]))
					pick = lo;
				r.status        = ST_NEAREST;
				r.removed_value = set_shadow[pick];
				set_shadow.delete(pick);
			end
		end
		return r;
	endfunction

	// One command transfer. start is lowered only when a gap precedes it, so
	// back-to-back transfers never see two assignments in one step.
	task automatic send_cmd(logic op, logic [ValW-1:0] key);
		ssne_in_t    c;
		int unsigned gap;
		c.opcode    = op;
		c.key_value = key;
		gap = burst_mode ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(apply_to_shadow(c));
		sent_count++;
	endtask

	// Result checker: every done pulse is one transfer, matched in order.
	always @(posedge clk) begin
		ssne_out_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d value=%0d",
				         $time, result.status, result.removed_value);
				err_count++;
			end else begin
				exp_r = pending_results.pop_front();
				checked_count++;
				if (result.status !== exp_r.status) begin
					$display("%0t: status mismatch exp=%0d act=%0d",
					         $time, exp_r.status, result.status);
					err_count++;
				end
				if (result.removed_value !== exp_r.removed_value) begin
					$display("%0t: removed_value mismatch exp=%0d act=%0d",
					         $time, exp_r.removed_value, result.removed_value);
					err_count++;
				end
			end
		end
	end

	task automatic test_directed();
		send_cmd(OP_REMOVE, 31'd5);        // empty set
		send_cmd(OP_INSERT, 31'd0);        // lowest key
		send_cmd(OP_INSERT, KEY_MAX);      // highest key
		send_cmd(OP_INSERT, KEY_MAX);      // duplicate
		send_cmd(OP_REMOVE, 31'd0);        // exact hit at the bottom
		send_cmd(OP_REMOVE, 31'd7);        // below the only value left
		send_cmd(OP_INSERT, 31'd10);
		send_cmd(OP_INSERT, 31'd20);
		send_cmd(OP_INSERT, 31'd30);
		send_cmd(OP_INSERT, 31'd20);       // duplicate in the middle
		send_cmd(OP_REMOVE, 31'd15);       // tie, lower neighbor wins
		send_cmd(OP_REMOVE, 31'd26);       // nearer upper neighbor
		send_cmd(OP_REMOVE, KEY_MAX);      // above everything
		send_cmd(OP_REMOVE, 31'd1);        // empty again
		send_cmd(OP_INSERT, 31'h2AAA_AAAA);
		send_cmd(OP_INSERT, 31'h5555_5555);
		send_cmd(OP_REMOVE, 31'd0);        // below everything
		send_cmd(OP_REMOVE, 31'h5555_5555);// exact, set drains
	endtask

	// Fill to capacity, poke the full set, then drain it with random targets.
	task automatic test_full_set();
		logic [ValW-1:0] k;
		burst_mode = 1'b1;
		while (set_shadow.size() < CAP) begin
			k = 31'($urandom_range(0, 4 * CAP));
			send_cmd(OP_INSERT, k);
		end
		burst_mode = 1'b0;
		send_cmd(OP_INSERT, set_shadow[0]);          // present while full
		send_cmd(OP_INSERT, set_shadow[CAP-1]);
		send_cmd(OP_INSERT, KEY_MAX);                // full
		send_cmd(OP_INSERT, 31'(4 * CAP + 1));       // full
		send_cmd(OP_REMOVE, KEY_MAX);                // top end of a full set
		send_cmd(OP_INSERT, KEY_MAX);                // refill the freed slot
		while (set_shadow.size() > 0) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			send_cmd(OP_REMOVE, 31'($urandom_range(0, 4 * CAP + 8)));
		end
		burst_mode = 1'b0;
	endtask

	task automatic test_random();
		logic            op;
		logic [ValW-1:0] k;
		int unsigned     n;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
			n = set_shadow.size();
			if (n < 6)       op = ($urandom_range(0, 5) == 0) ? OP_REMOVE : OP_INSERT;
			else if (n > 48) op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_REMOVE;
			else             op = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: k = 31'($urandom_range(0, 255));
				1: k = 31'($urandom());
				2: begin
					if (n > 0) k = set_shadow[$urandom_range(0, n - 1)] +
					               31'($urandom_range(0, 6)) - 31'd3;
					else k = 31'($urandom_range(0, 255));
				end
				default: begin
					case ($urandom_range(0, 3))
						0: k = 31'd0;
						1: k = 31'd1;
						2: k = KEY_MAX - 31'd1;
						default: k = KEY_MAX;
					endcase
				end
			endcase
			send_cmd(op, k);
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		sent_count    = 0;
		burst_mode    = 1'b0;
		arst_n        = 1'b0;
		start        <= 1'b0;
		cmd          <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_set();
		test_random();

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * CAP + 16) @(posedge clk);

		$display("Ran %0d commands through directed, full-set and random phases;",
		         sent_count);
		$display("%0d results checked, %0d mismatches.", checked_count, err_count);
		if (err_count == 0 && pending_results.size() == 0)
			$display("** sorted_set_nearest_extract_unit: PASSED **");
		else
			$display("** sorted_set_nearest_extract_unit: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
src/ssne_pkg.sv
src/ssne_mem.sv
src/sorted_set_nearest_extract_unit.sv
verif/testbench.sv
